[src/mbc3rtc_pkg.sv]
// Shared types and codes of the cartridge bank controller with real-time clock.
`timescale 1ns / 1ps

package mbc3rtc_pkg;

  // Function of an input word.
  typedef enum logic [1:0] {
    FuncWrite = 2'd0,
    FuncRead  = 2'd1,
    FuncTick  = 2'd2,
    FuncIdle  = 2'd3
  } func_e;

  // Controller register picked by address bits 15..13.
  typedef enum logic [2:0] {
    RegRamEnable = 3'd0,
    RegRomBank   = 3'd1,
    RegRamBank   = 3'd2,
    RegLatch     = 3'd3,
    RegWindow    = 3'd5
  } region_e;

  // Configuration register indexes.
  typedef enum logic {
    CfgRomMask  = 1'b0,
    CfgRamCount = 1'b1
  } cfg_e;

  localparam int unsigned RtcRegs     = 5;
  localparam logic [3:0]  RamEnKey    = 4'hA;
  localparam logic [3:0]  RtcSelFirst = 4'd8;
  localparam logic [3:0]  RtcSelLast  = 4'd12;
  localparam logic [7:0]  OpenBus     = 8'hFF;
  localparam logic [6:0]  RomMaskRst  = 7'd127;
  localparam logic [3:0]  RamCountRst = 4'd4;
  localparam int unsigned DayHaltBit  = 6;
  localparam int unsigned DayCarryBit = 7;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] addr;
    logic [7:0]  data;
  } in_word_t;

  typedef struct packed {
    logic [6:0] rom_bank;
    logic [3:0] ram_bank;
    logic       ram_mapped;
    logic [7:0] read_data;
    logic       read_hit;
  } out_word_t;

endpackage

[src/mbc3rtc_word_if.sv]
// Valid/ready channel that carries one word of a given payload type.
`timescale 1ns / 1ps

interface mbc3rtc_word_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[src/mbc3_bank_controller_rtc_core.sv]
// Top level: cartridge bank controller with real-time clock.
//
// Usage: in_i carries words of mbc3rtc_pkg::in_word_t (bus write, window read
// or one-second tick); out_o returns exactly one mbc3rtc_pkg::out_word_t per
// accepted word, in order, with the bank state after that word. The
// configuration port writes the ROM bank mask (index 0) and the RAM bank count
// (index 1); the user must write it only while idle; the block does not check.
// The update, a small decode plus a chain of seconds, minutes, hours and day
// carries, sits ahead of the result register (the skid register on a stall).
// Throughput is one word per cycle while out_o does not stall.
// A stalled receiver holds the result register; one more word is taken into a
// skid register, and in_i.ready drops only while that skid register is full.
// Reset clears the bank selects (ROM bank 1), the RAM enable, the latch
// history and both clock copies, loads the default configuration, and empties
// the output side.
`timescale 1ns / 1ps

module mbc3_bank_controller_rtc_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [6:0]            cfg_data_i,
  mbc3rtc_word_if.sink          in_i,
  mbc3rtc_word_if.source        out_o
);
  import mbc3rtc_pkg::*;

  typedef struct packed {
    logic [2:0] q;
    logic [5:0] r;
  } div60_t;

  typedef struct packed {
    logic [3:0] q;
    logic [4:0] r;
  } div24_t;

  // Operands here stay below 260, so the quotient by 60 is at most 4.
  function automatic div60_t div60(input logic [8:0] v);
    div60_t res;
    logic [8:0] rem;
    res.q = '0;
    for (int k = 1; k <= 4; k++) begin
      if (v >= 9'(k * 60)) res.q = 3'(k);
    end
    rem   = v - ({6'b0, res.q} * 9'd60);
    res.r = rem[5:0];
    return res;
  endfunction

  // Operands stay below 260, so the quotient by 24 is at most 10.
  function automatic div24_t div24(input logic [8:0] v);
    div24_t res;
    logic [8:0] rem;
    res.q = '0;
    for (int k = 1; k <= 10; k++) begin
      if (v >= 9'(k * 24)) res.q = 4'(k);
    end
    rem   = v - ({5'b0, res.q} * 9'd24);
    res.r = rem[4:0];
    return res;
  endfunction

  logic [6:0] rom_mask_q;
  logic [3:0] ram_count_q;

  logic       ram_enable_q, ram_enable_d;
  logic [6:0] rom_select_q, rom_select_d;
  logic [3:0] ram_select_q, ram_select_d;
  logic [7:0] latch_last_q, latch_last_d;
  logic [7:0] clock_live_q    [RtcRegs];
  logic [7:0] clock_live_d    [RtcRegs];
  logic [7:0] clock_latched_q [RtcRegs];
  logic [7:0] clock_latched_d [RtcRegs];

  logic       out_valid_q, skid_valid_q;
  out_word_t  out_q, skid_q, result;

  logic       in_fire, out_free;
  logic       ram_mapped_cur, rtc_sel;
  logic [2:0] rtc_idx;
  logic [6:0] rom_pick;

  // Tick arithmetic.
  logic [8:0] sec_inc, min_sum, hour_sum;
  logic [9:0] day_sum;
  div60_t     sec_div, min_div;
  div24_t     hour_div;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = !skid_valid_q;

  assign ram_mapped_cur = ram_enable_q && (ram_select_q < ram_count_q);
  assign rtc_sel = ram_enable_q && !ram_mapped_cur &&
                   (ram_select_q >= RtcSelFirst) && (ram_select_q <= RtcSelLast);
  assign rtc_idx = 3'(ram_select_q - RtcSelFirst);

  assign rom_pick = (in_i.payload.data[6:0] == 7'd0) ? 7'd1 : in_i.payload.data[6:0];

  // The clock is renormalized as mixed radix, so stored values out of range
  // carry into the next field the same way a total-seconds split would.
  always_comb begin
    sec_inc  = {1'b0, clock_live_q[0]} + 9'd1;
    sec_div  = div60(sec_inc);
    min_sum  = {1'b0, clock_live_q[1]} + {6'b0, sec_div.q};
    min_div  = div60(min_sum);
    hour_sum = {1'b0, clock_live_q[2]} + {6'b0, min_div.q};
    hour_div = div24(hour_sum);
    day_sum  = {1'b0, clock_live_q[4][0], clock_live_q[3]} + {6'b0, hour_div.q};
  end

  always_comb begin
    ram_enable_d    = ram_enable_q;
    rom_select_d    = rom_select_q;
    ram_select_d    = ram_select_q;
    latch_last_d    = latch_last_q;
    clock_live_d    = clock_live_q;
    clock_latched_d = clock_latched_q;
    result.read_data = OpenBus;
    result.read_hit  = 1'b0;

    if (in_fire) begin
      unique case (func_e'(in_i.payload.func))
        FuncWrite: begin
          unique case (in_i.payload.addr[15:13])
            RegRamEnable: ram_enable_d = (in_i.payload.data[3:0] == RamEnKey);
            RegRomBank:   rom_select_d = rom_pick & rom_mask_q;
            RegRamBank:   ram_select_d = in_i.payload.data[3:0];
            RegLatch: begin
              if ((latch_last_q == 8'd0) && (in_i.payload.data == 8'd1)) begin
                clock_latched_d = clock_live_q;
              end
              latch_last_d = in_i.payload.data;
            end
            RegWindow: begin
              if (rtc_sel) clock_live_d[rtc_idx] = in_i.payload.data;
            end
            default: ;
          endcase
        end
        FuncRead: begin
          if (rtc_sel) begin
            result.read_data = clock_latched_q[rtc_idx];
            result.read_hit  = 1'b1;
          end
        end
        FuncTick: begin
          if (!clock_live_q[4][DayHaltBit]) begin
            clock_live_d[0] = {2'b0, sec_div.r};
            clock_live_d[1] = {2'b0, min_div.r};
            clock_live_d[2] = {3'b0, hour_div.r};
            clock_live_d[3] = day_sum[7:0];
            clock_live_d[4] = {clock_live_q[4][DayCarryBit] | day_sum[9],
                               clock_live_q[4][6:1], day_sum[8]};
          end
        end
        FuncIdle: ;
        default: ;
      endcase
    end

    result.rom_bank   = rom_select_d;
    result.ram_bank   = ram_select_d;
    result.ram_mapped = ram_enable_d && (ram_select_d < ram_count_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_mask_q  <= RomMaskRst;
      ram_count_q <= RamCountRst;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_index_i))
        CfgRomMask:  rom_mask_q  <= cfg_data_i;
        CfgRamCount: ram_count_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_enable_q <= 1'b0;
      rom_select_q <= 7'd1;
      ram_select_q <= 4'd0;
      latch_last_q <= 8'd0;
      for (int i = 0; i < RtcRegs; i++) begin
        clock_live_q[i]    <= 8'd0;
        clock_latched_q[i] <= 8'd0;
      end
    end else begin
      ram_enable_q    <= ram_enable_d;
      rom_select_q    <= rom_select_d;
      ram_select_q    <= ram_select_d;
      latch_last_q    <= latch_last_d;
      clock_live_q    <= clock_live_d;
      clock_latched_q <= clock_latched_d;
    end
  end

  // Output register with a one-word skid register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= result;
      end
    end else if (in_fire) begin
      skid_q <= result;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held without a word in the output register");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && out_valid_q && !out_o.ready) |=> skid_valid_q)
    else $error("word accepted during a stall was not kept in the skid register");

  a_hit_is_clock_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.read_hit) |->
      (!out_q.ram_mapped && (out_q.ram_bank >= RtcSelFirst) &&
       (out_q.ram_bank <= RtcSelLast)))
    else $error("clock read hit reported without a clock register selected");

endmodule

[tb/mbc3_bank_controller_rtc_core_test.sv]
// Self-checking testbench of the cartridge bank controller with real-time clock.
`timescale 1ns / 1ps

module mbc3_bank_controller_rtc_core_test;
  import mbc3rtc_pkg::*;

  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned MinsPerHour = 60;
  localparam int unsigned HoursPerDay = 24;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned StuckLimit  = 2000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned PrintCap    = 40;
  localparam int unsigned SweepWords  = 230;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [6:0] cfg_data;

  mbc3rtc_word_if #(.payload_t(in_word_t))  bus_in ();
  mbc3rtc_word_if #(.payload_t(out_word_t)) bank_out ();

  mbc3_bank_controller_rtc_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_i        (bus_in),
    .out_o       (bank_out)
  );

  // Mirror of the controller state and configuration.
  logic [6:0] rom_mask_m;
  logic [3:0] ram_count_m;
  logic       ram_en_m;
  logic [6:0] rom_sel_m;
  logic [3:0] ram_sel_m;
  logic [7:0] latch_prev_m;
  logic [7:0] clk_live_m [RtcRegs];
  logic [7:0] clk_snap_m [RtcRegs];

  out_word_t   bank_state_q[$];
  int unsigned mismatches;
  int unsigned stuck_cycles;
  int unsigned hold_req;
  bit          steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_word_t mk_word(func_e f, logic [15:0] a, logic [7:0] d);
    in_word_t w;
    w.func = f;
    w.addr = a;
    w.data = d;
    return w;
  endfunction

  // Applies one word to the mirror and returns the bank state after it.
  function automatic out_word_t next_bank_state(input in_word_t w);
    out_word_t   res;
    logic        rtc_sel;
    logic [2:0]  idx;
    logic [6:0]  bank;
    logic [7:0]  dh;
    int unsigned total;
    rtc_sel = ram_en_m && !(ram_sel_m < ram_count_m) &&
              ram_sel_m >= RtcSelFirst && ram_sel_m <= RtcSelLast;
    idx = 3'(ram_sel_m - RtcSelFirst);
    res.read_data = OpenBus;
    res.read_hit  = 1'b0;
    case (w.func)
      FuncWrite: begin
        case (w.addr[15:13])
          RegRamEnable: ram_en_m = (w.data[3:0] == RamEnKey);
          RegRomBank: begin
            bank = w.data[6:0];
            if (bank == 7'd0) bank = 7'd1;
            rom_sel_m = bank & rom_mask_m;
          end
          RegRamBank: ram_sel_m = w.data[3:0];
          RegLatch: begin
            if (latch_prev_m == 8'd0 && w.data == 8'd1) clk_snap_m = clk_live_m;
            latch_prev_m = w.data;
          end
          RegWindow: if (rtc_sel) clk_live_m[idx] = w.data;
          default: ;
        endcase
      end
      FuncRead: begin
        if (rtc_sel) begin
          res.read_data = clk_snap_m[idx];
          res.read_hit  = 1'b1;
        end
      end
      FuncTick: begin
        if (!clk_live_m[4][DayHaltBit]) begin
          // Stored bytes are taken whole, so out-of-range values renormalize here.
          total = clk_live_m[0] + clk_live_m[1] * SecsPerMin + clk_live_m[2] * SecsPerHour
                + {clk_live_m[4][0], clk_live_m[3]} * SecsPerDay + 1;
          clk_live_m[0] = 8'(total % SecsPerMin);
          total = total / SecsPerMin;
          clk_live_m[1] = 8'(total % MinsPerHour);
          total = total / MinsPerHour;
          clk_live_m[2] = 8'(total % HoursPerDay);
          total = total / HoursPerDay;
          clk_live_m[3] = total[7:0];
          total = total >> 8;
          dh = clk_live_m[4];
          dh[0] = total[0];
          if (total >= 2) dh[DayCarryBit] = 1'b1;
          clk_live_m[4] = dh;
        end
      end
      default: ;
    endcase
    res.rom_bank   = rom_sel_m;
    res.ram_bank   = ram_sel_m;
    res.ram_mapped = ram_en_m && (ram_sel_m < ram_count_m);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PrintCap) $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Mostly short gaps, a few long ones, none at all in steady stretches.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random word, mostly well-formed controller accesses with random content.
  function automatic in_word_t rand_word();
    int unsigned pick;
    logic [12:0] low;
    logic [7:0]  d;
    logic [7:0]  clock_vals [8];
    clock_vals = '{8'd0, 8'd1, 8'd23, 8'd59, 8'h3F, 8'h41, 8'h80, 8'hFF};
    pick = $urandom_range(0, 99);
    low  = 13'($urandom_range(0, 13'h1FFF));
    d    = 8'($urandom_range(0, 255));
    if (pick < 15) return mk_word(FuncTick, 16'($urandom_range(0, 16'hFFFF)), d);
    if (pick < 30) begin
      if ($urandom_range(0, 3) == 0) return mk_word(FuncRead, 16'($urandom_range(0, 16'hFFFF)), d);
      return mk_word(FuncRead, {RegWindow, low}, d);
    end
    if (pick < 38) begin
      if ($urandom_range(0, 1) != 0) d[3:0] = RamEnKey;
      return mk_word(FuncWrite, {RegRamEnable, low}, d);
    end
    if (pick < 45) begin
      if ($urandom_range(0, 4) == 0) d[6:0] = 7'd0;
      return mk_word(FuncWrite, {RegRomBank, low}, d);
    end
    if (pick < 58) begin
      if ($urandom_range(0, 3) != 0) d[3:0] = 4'($urandom_range(RtcSelFirst, RtcSelLast));
      return mk_word(FuncWrite, {RegRamBank, low}, d);
    end
    if (pick < 66) begin
      if ($urandom_range(0, 4) != 0) d = 8'($urandom_range(0, 1));
      return mk_word(FuncWrite, {RegLatch, low}, d);
    end
    if (pick < 90) begin
      if ($urandom_range(0, 1) != 0) d = clock_vals[$urandom_range(0, 7)];
      return mk_word(FuncWrite, {RegWindow, low}, d);
    end
    return mk_word(func_e'($urandom_range(0, 3)), 16'($urandom_range(0, 16'hFFFF)), d);
  endfunction

  task automatic send_word(input in_word_t w);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      bus_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    bus_in.valid   <= 1'b1;
    bus_in.payload <= w;
    @(posedge clk);
    while (!bus_in.ready) @(posedge clk);
  endtask

  // Stops offering words and waits until every expected bank state has come back.
  task automatic drain();
    @(negedge clk);
    bus_in.valid <= 1'b0;
    while (bank_state_q.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_cfg(input cfg_e idx, input logic [6:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic test_directed();
    send_word(mk_word(FuncIdle,  16'hFFFF, 8'hFF));
    send_word(mk_word(FuncWrite, 16'h0000, 8'h0A));
    send_word(mk_word(FuncWrite, 16'h2000, 8'h00));
    send_word(mk_word(FuncWrite, 16'h3FFF, 8'hFF));
    send_word(mk_word(FuncWrite, 16'h2100, 8'h80));
    // Clock set to the last second of day 511, then one tick wraps it.
    send_word(mk_word(FuncWrite, 16'h4000, 8'h08));
    send_word(mk_word(FuncWrite, 16'hA000, 8'd59));
    send_word(mk_word(FuncWrite, 16'h4000, 8'h09));
    send_word(mk_word(FuncWrite, 16'hBFFF, 8'd59));
    send_word(mk_word(FuncWrite, 16'h4000, 8'h0A));
    send_word(mk_word(FuncWrite, 16'hA123, 8'd23));
    send_word(mk_word(FuncWrite, 16'h4000, 8'h0B));
    send_word(mk_word(FuncWrite, 16'hA000, 8'hFF));
    send_word(mk_word(FuncWrite, 16'h5FFF, 8'hFC));
    send_word(mk_word(FuncWrite, 16'hA000, 8'h01));
    send_word(mk_word(FuncTick,  16'h0000, 8'h00));
    send_word(mk_word(FuncWrite, 16'h6000, 8'h00));
    send_word(mk_word(FuncWrite, 16'h7FFF, 8'h01));
    send_word(mk_word(FuncRead,  16'hBFFF, 8'h00));
    // Halted clock ignores the tick; an out-of-range second renormalizes later.
    send_word(mk_word(FuncWrite, 16'hA000, 8'h41));
    send_word(mk_word(FuncTick,  16'hFFFF, 8'hFF));
    send_word(mk_word(FuncWrite, 16'h4000, 8'h08));
    send_word(mk_word(FuncWrite, 16'hA000, 8'hFF));
    send_word(mk_word(FuncWrite, 16'h6000, 8'h01));
    send_word(mk_word(FuncWrite, 16'h4000, 8'h0C));
    send_word(mk_word(FuncWrite, 16'hA000, 8'h00));
    send_word(mk_word(FuncTick,  16'h8000, 8'h00));
    send_word(mk_word(FuncWrite, 16'h4000, 8'h03));
    send_word(mk_word(FuncRead,  16'hA000, 8'h00));
    send_word(mk_word(FuncWrite, 16'h8000, 8'h0D));
    send_word(mk_word(FuncWrite, 16'hC000, 8'h0D));
    send_word(mk_word(FuncWrite, 16'hE000, 8'h0D));
    send_word(mk_word(FuncWrite, 16'h1FFF, 8'hF0));
    send_word(mk_word(FuncRead,  16'hA000, 8'h00));
    drain();
  endtask

  task automatic test_full_rate();
    steady = 1'b1;
    repeat (120) send_word(rand_word());
    drain();
    steady = 1'b0;
  endtask

  // The receiver holds off long enough for the skid register to fill.
  task automatic test_backpressure();
    steady   = 1'b1;
    hold_req = HoldCycles;
    repeat (60) send_word(rand_word());
    drain();
    steady = 1'b0;
  endtask

  task automatic test_config_sweep();
    logic [6:0] masks  [6];
    logic [3:0] counts [6];
    masks  = '{7'd1, 7'd127, 7'd3, 7'd15, 7'd0, 7'd0};
    counts = '{4'd0, 4'd8, 4'd1, 4'd4, 4'd0, 4'd0};
    for (int i = 4; i < 6; i++) begin
      masks[i]  = 7'((1 << $urandom_range(1, 7)) - 1);
      counts[i] = 4'($urandom_range(0, 8));
    end
    for (int i = 0; i < 6; i++) begin
      write_cfg(CfgRomMask, masks[i]);
      write_cfg(CfgRamCount, {3'd0, counts[i]});
      repeat (SweepWords) send_word(rand_word());
      drain();
    end
  endtask

  initial begin
    bank_out.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      int unsigned stall;
      @(negedge clk);
      if (hold_req != 0) begin
        bank_out.ready <= 1'b0;
        repeat (hold_req - 1) @(negedge clk);
        hold_req = 0;
      end else begin
        stall = pick_gap();
        if (stall != 0) begin
          bank_out.ready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
        end else begin
          bank_out.ready <= 1'b1;
        end
      end
    end
  end

  // Checks the result leaving at this edge, then records the word entering at it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (bank_out.valid && bank_out.ready) begin
        if (bank_state_q.size() == 0) begin
          report_mismatch("bank state word with none expected");
        end else begin
          out_word_t exp_w;
          out_word_t got_w;
          exp_w = bank_state_q.pop_front();
          got_w = bank_out.payload;
          if (got_w.rom_bank !== exp_w.rom_bank)
            report_mismatch($sformatf("rom_bank %h, expected %h", got_w.rom_bank, exp_w.rom_bank));
          if (got_w.ram_bank !== exp_w.ram_bank)
            report_mismatch($sformatf("ram_bank %h, expected %h", got_w.ram_bank, exp_w.ram_bank));
          if (got_w.ram_mapped !== exp_w.ram_mapped)
            report_mismatch($sformatf("ram_mapped %b, expected %b",
                                      got_w.ram_mapped, exp_w.ram_mapped));
          if (got_w.read_data !== exp_w.read_data)
            report_mismatch($sformatf("read_data %h, expected %h",
                                      got_w.read_data, exp_w.read_data));
          if (got_w.read_hit !== exp_w.read_hit)
            report_mismatch($sformatf("read_hit %b, expected %b", got_w.read_hit, exp_w.read_hit));
        end
      end
      if (bus_in.valid && bus_in.ready) bank_state_q.push_back(next_bank_state(bus_in.payload));
      if (cfg_we) begin
        if (cfg_index == CfgRomMask) rom_mask_m = cfg_data;
        else ram_count_m = cfg_data[3:0];
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (bus_in.valid && bus_in.ready) || (bank_out.valid && bank_out.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("mbc3_bank_controller_rtc_core_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CfgRomMask;
    cfg_data       = 7'd0;
    bus_in.valid   = 1'b0;
    bus_in.payload = '0;
    mismatches     = 0;
    stuck_cycles   = 0;
    hold_req       = 0;
    steady         = 1'b0;
    rom_mask_m     = RomMaskRst;
    ram_count_m    = RamCountRst;
    ram_en_m       = 1'b0;
    rom_sel_m      = 7'd1;
    ram_sel_m      = 4'd0;
    latch_prev_m   = 8'd0;
    for (int i = 0; i < RtcRegs; i++) begin
      clk_live_m[i] = 8'd0;
      clk_snap_m[i] = 8'd0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_full_rate();
    test_backpressure();
    test_config_sweep();

    drain();
    repeat (4) @(posedge clk);
    if (bank_state_q.size() != 0)
      report_mismatch($sformatf("%0d bank state words never arrived", bank_state_q.size()));
    if (mismatches == 0) begin
      $display("mbc3_bank_controller_rtc_core_test OK");
    end else begin
      $display("mbc3_bank_controller_rtc_core_test NOT OK");
    end
    $finish;
  end

endmodule
